// ----- hw/rtl/fcull_pkg.sv -----
package fcull_pkg;

    // plane storage and test depth
    localparam int PLANE_COUNT = 6;
    localparam int REG_COUNT   = 6;
    localparam int CELL_COUNT  = (PLANE_COUNT < REG_COUNT) ? PLANE_COUNT : REG_COUNT;

    // field widths
    localparam int OP_W    = 2;
    localparam int COORD_W = 16;
    localparam int EXT_W   = 15;
    localparam int COEF_W  = 16;
    localparam int PLANE_W = 4 * COEF_W;
    localparam int CFG_IDX_W = 3;

    // arithmetic widths: corner coordinate, product, bias, distance
    localparam int CORNER_W = COORD_W + 1;
    localparam int PROD_W   = COEF_W + CORNER_W;
    localparam int BIAS_W   = COORD_W + 1;
    localparam int D_SHIFT  = 13;
    localparam int DIST_W   = PROD_W + 3;

    // query kinds
    localparam logic [OP_W-1:0] OP_POINT    = 2'd0;
    localparam logic [OP_W-1:0] OP_SPHERE   = 2'd1;
    localparam logic [OP_W-1:0] OP_BOX      = 2'd2;
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_NEAR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_FAR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_LEFT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_RIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_TOP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_BOTTOM = 3'd5;

    typedef logic [REG_COUNT-1:0] t_plane_sel;

    // one query travelling down the cell chain
    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic [EXT_W-1:0]          ex;
        logic [EXT_W-1:0]          ey;
        logic [EXT_W-1:0]          ez;
        logic                      pass;
    } t_query;

    // coordinate of the corner furthest along the normal, or the centre itself
    function automatic logic signed [CORNER_W-1:0] corner(
        input logic signed [COORD_W-1:0] c,
        input logic [EXT_W-1:0]          e,
        input logic                      neg,
        input logic                      box
    );
        logic signed [CORNER_W-1:0] cw;
        logic signed [CORNER_W-1:0] ew;
        cw = $signed({c[COORD_W-1], c});
        ew = $signed({{(CORNER_W-EXT_W){1'b0}}, e});
        if (!box) begin
            return cw;
        end else if (neg) begin
            return cw - ew;
        end else begin
            return cw + ew;
        end
    endfunction

endpackage

// ----- hw/rtl/fcull_cell.sv -----
module fcull_cell
    import fcull_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_we,
    input  logic [PLANE_W-1:0] i_wdata,
    input  logic               i_valid,
    input  t_query             i_query,
    output logic               o_valid,
    output t_query             o_query
);

    logic [PLANE_W-1:0] r_plane;

    logic signed [COEF_W-1:0] w_a, w_b, w_c, w_d;
    logic                     w_box, w_sphere;
    logic signed [CORNER_W-1:0] w_kx, w_ky, w_kz;
    logic signed [PROD_W-1:0]   n_px, n_py, n_pz;
    logic signed [BIAS_W-1:0]   n_bias;

    logic                     r1_vld;
    t_query                   r1_query;
    logic signed [PROD_W-1:0] r1_px, r1_py, r1_pz;
    logic signed [BIAS_W-1:0] r1_bias;

    logic signed [DIST_W-1:0] w_dist;
    logic                     r2_vld;
    t_query                   r2_query;
    t_query                   n2_query;

    // plane register held by this cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
        end else if (i_we) begin
            r_plane <= i_wdata;
        end
    end

    assign w_a = $signed(r_plane[COEF_W-1:0]);
    assign w_b = $signed(r_plane[2*COEF_W-1:COEF_W]);
    assign w_c = $signed(r_plane[3*COEF_W-1:2*COEF_W]);
    assign w_d = $signed(r_plane[4*COEF_W-1:3*COEF_W]);

    // query kind decode
    always_comb begin
        w_box    = 1'b0;
        w_sphere = 1'b0;
        unique case (i_query.op) inside
            OP_POINT:             ;
            OP_SPHERE:            w_sphere = 1'b1;
            OP_BOX, OP_RESERVED:  w_box = 1'b1;
            default:              w_box = 1'b1;
        endcase
    end

    // stage one: corner pick and the three products
    assign w_kx = corner(i_query.cx, i_query.ex, w_a[COEF_W-1], w_box);
    assign w_ky = corner(i_query.cy, i_query.ey, w_b[COEF_W-1], w_box);
    assign w_kz = corner(i_query.cz, i_query.ez, w_c[COEF_W-1], w_box);

    assign n_px = PROD_W'(w_a) * PROD_W'(w_kx);
    assign n_py = PROD_W'(w_b) * PROD_W'(w_ky);
    assign n_pz = PROD_W'(w_c) * PROD_W'(w_kz);

    // d plus the radius for a sphere, scaled later
    assign n_bias = $signed({w_d[COEF_W-1], w_d})
                  + (w_sphere ? $signed({{(BIAS_W-EXT_W){1'b0}}, i_query.ex})
                              : $signed({BIAS_W{1'b0}}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_adv) begin
            r1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_query <= i_query;
            r1_px    <= n_px;
            r1_py    <= n_py;
            r1_pz    <= n_pz;
            r1_bias  <= n_bias;
        end
    end

    // stage two: full width sum and sign test
    assign w_dist = DIST_W'(r1_px) + DIST_W'(r1_py) + DIST_W'(r1_pz)
                  + DIST_W'($signed({r1_bias, {D_SHIFT{1'b0}}}));

    always_comb begin
        n2_query      = r1_query;
        n2_query.pass = r1_query.pass & ~w_dist[DIST_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_adv) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r2_query <= n2_query;
        end
    end

    assign o_valid = r2_vld;
    assign o_query = r2_query;

endmodule

// ----- hw/rtl/frustum_cull_test.sv -----
// Frustum cull test: each query item (point, sphere or axis-aligned box) is checked against
// the stored planes by a chain of cells, one per plane, each holding its plane register. A
// cell spends two register stages on an item (three coefficient products, then the exact
// sum and sign test), so a result leaves through both stages of every cell and then the
// output register. One item is taken in every cycle unless a finished result is held by
// an output stall; that freezes the whole chain. Plane registers reset to zero, which
// makes every query visible. The user writes them through the configuration port while the
// block is idle (not enforced by the block); indexes of six and above are ignored.
module frustum_cull_test
    import fcull_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // query items
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [OP_W-1:0]           i_operation,
    input  logic signed [COORD_W-1:0] i_center_x,
    input  logic signed [COORD_W-1:0] i_center_y,
    input  logic signed [COORD_W-1:0] i_center_z,
    input  logic [EXT_W-1:0]          i_extent_x,
    input  logic [EXT_W-1:0]          i_extent_y,
    input  logic [EXT_W-1:0]          i_extent_z,
    // result items
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_visible,
    // configuration writes
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [PLANE_W-1:0]        i_cfg_data
);

    logic                  w_adv;
    t_plane_sel            w_sel;
    logic [CELL_COUNT:0]   w_vld;
    t_query                w_query [0:CELL_COUNT];
    logic                  r_out_valid;
    logic                  r_visible;

    // chain moves unless a finished result is held
    assign w_adv      = !(r_out_valid && i_out_stall);
    assign o_in_stall = !w_adv;
    assign o_cfg_ready = 1'b1;

    // register index decode
    always_comb begin
        w_sel = '0;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_PLANE_NEAR:   w_sel[REG_PLANE_NEAR]   = 1'b1;
                REG_PLANE_FAR:    w_sel[REG_PLANE_FAR]    = 1'b1;
                REG_PLANE_LEFT:   w_sel[REG_PLANE_LEFT]   = 1'b1;
                REG_PLANE_RIGHT:  w_sel[REG_PLANE_RIGHT]  = 1'b1;
                REG_PLANE_TOP:    w_sel[REG_PLANE_TOP]    = 1'b1;
                REG_PLANE_BOTTOM: w_sel[REG_PLANE_BOTTOM] = 1'b1;
                default:          w_sel = '0;
            endcase
        end
    end

    // item entering the chain
    assign w_vld[0]         = i_in_valid && w_adv;
    assign w_query[0].op    = i_operation;
    assign w_query[0].cx    = i_center_x;
    assign w_query[0].cy    = i_center_y;
    assign w_query[0].cz    = i_center_z;
    assign w_query[0].ex    = i_extent_x;
    assign w_query[0].ey    = i_extent_y;
    assign w_query[0].ez    = i_extent_z;
    assign w_query[0].pass  = 1'b1;

    // one cell per tested plane
    for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
        fcull_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_we    (w_sel[k]),
            .i_wdata (i_cfg_data),
            .i_valid (w_vld[k]),
            .i_query (w_query[k]),
            .o_valid (w_vld[k+1]),
            .o_query (w_query[k+1])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_vld[CELL_COUNT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_visible <= w_query[CELL_COUNT].pass;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_visible   = r_visible;

    // item leaving the last cell lands in the output register
    a_last_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vld[CELL_COUNT] && w_adv) |=> r_out_valid)
        else $error("item from last cell lost");

    // held result freezes the chain
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> $stable(w_vld[CELL_COUNT:1]))
        else $error("chain moved while output stalled");

    // nothing is shown right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid)
        else $error("result valid after reset");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import fcull_pkg::*;

    // indexes past the plane registers, which the block must ignore
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    localparam int HOLD_CYCLES = 120;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 2 * CELL_COUNT + 8;

    // fixed-point values used by the directed cube
    localparam int ONE_Q13 = 8192;
    localparam int HALF_SIDE = 1600;

    typedef struct packed {
        logic [OP_W-1:0]           kind;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic [EXT_W-1:0]          ex;
        logic [EXT_W-1:0]          ey;
        logic [EXT_W-1:0]          ez;
    } cull_query_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic [OP_W-1:0]           i_operation = OP_POINT;
    logic signed [COORD_W-1:0] i_center_x = '0;
    logic signed [COORD_W-1:0] i_center_y = '0;
    logic signed [COORD_W-1:0] i_center_z = '0;
    logic [EXT_W-1:0]          i_extent_x = '0;
    logic [EXT_W-1:0]          i_extent_y = '0;
    logic [EXT_W-1:0]          i_extent_z = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic                      o_visible;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [PLANE_W-1:0]        i_cfg_data = '0;

    // predictor state and expected results
    logic [PLANE_W-1:0] plane_model [REG_COUNT];
    logic               vis_expected [$];
    int                 mismatches = 0;
    int                 results_seen = 0;

    // idling controls
    bit in_idle_on = 1'b0;
    bit out_idle_on = 1'b0;
    int holds_asked = 0;
    int holds_served = 0;
    int hold_left = 0;
    int stall_left = 0;
    int quiet_cycles = 0;

    logic want_vis;

    wire took_in  = i_in_valid && !o_in_stall;
    wire took_out = o_out_valid && !i_out_stall;
    wire took_cfg = i_cfg_valid && o_cfg_ready;

    frustum_cull_test dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_operation(i_operation),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_center_z (i_center_z),
        .i_extent_x (i_extent_x),
        .i_extent_y (i_extent_y),
        .i_extent_z (i_extent_z),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_visible  (o_visible),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // visibility of one query against the current planes, all sums exact
    function automatic logic predict_visible(input cull_query_t q);
        logic signed [COEF_W-1:0] ca, cb, cc, cd;
        longint a, b, c, d, x, y, z, ex, ey, ez, plane_sum, reach;
        logic vis;
        logic pass;
        vis = 1'b1;
        x = longint'(q.cx);
        y = longint'(q.cy);
        z = longint'(q.cz);
        ex = longint'(q.ex);
        ey = longint'(q.ey);
        ez = longint'(q.ez);
        for (int n = 0; n < CELL_COUNT; n++) begin
            {cd, cc, cb, ca} = plane_model[n];
            a = longint'(ca);
            b = longint'(cb);
            c = longint'(cc);
            d = longint'(cd);
            plane_sum = a * x + b * y + c * z + (d <<< D_SHIFT);
            if (q.kind == OP_POINT) begin
                pass = (plane_sum >= 0);
            end else if (q.kind == OP_SPHERE) begin
                pass = (plane_sum >= -(ex <<< D_SHIFT));
            end else begin
                // box and reserved kind: corner furthest along the normal
                reach = (a < 0 ? -a : a) * ex + (b < 0 ? -b : b) * ey
                      + (c < 0 ? -c : c) * ez;
                pass = (plane_sum + reach >= 0);
            end
            vis = vis & pass;
        end
        return vis;
    endfunction

    function automatic cull_query_t query_of(input logic [OP_W-1:0] kind, input int cx,
                                             input int cy, input int cz, input int ex,
                                             input int ey, input int ez);
        cull_query_t q;
        q.kind = kind;
        q.cx = COORD_W'(cx);
        q.cy = COORD_W'(cy);
        q.cz = COORD_W'(cz);
        q.ex = EXT_W'(ex);
        q.ey = EXT_W'(ey);
        q.ez = EXT_W'(ez);
        return q;
    endfunction

    function automatic logic [PLANE_W-1:0] plane_of(input int a, input int b, input int c,
                                                   input int d);
        logic [COEF_W-1:0] fa, fb, fc, fd;
        fa = COEF_W'(a);
        fb = COEF_W'(b);
        fc = COEF_W'(c);
        fd = COEF_W'(d);
        return {fd, fc, fb, fa};
    endfunction

    // random query; narrow ones keep coordinates near the origin
    function automatic cull_query_t random_query();
        cull_query_t q;
        bit wide;
        wide = 1'($urandom_range(0, 1));
        q.kind = OP_W'($urandom_range(0, 3));
        q.cx = COORD_W'(wide ? $urandom : $urandom_range(0, 8191) - 4096);
        q.cy = COORD_W'(wide ? $urandom : $urandom_range(0, 8191) - 4096);
        q.cz = COORD_W'(wide ? $urandom : $urandom_range(0, 8191) - 4096);
        q.ex = EXT_W'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1023));
        q.ey = EXT_W'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1023));
        q.ez = EXT_W'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1023));
        return q;
    endfunction

    // random plane: pass-all, arbitrary, axis-aligned or extreme fields
    function automatic logic [PLANE_W-1:0] random_plane();
        int pick;
        int mag;
        int sel;
        int ext [3];
        pick = $urandom_range(0, 9);
        mag = ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(1, 16383);
        sel = $urandom_range(0, 2);
        ext[0] = -32768;
        ext[1] = 32767;
        ext[2] = 0;
        if (pick <= 2) begin
            return plane_of(0, 0, 0, $urandom_range(0, 32767));
        end else if (pick <= 4) begin
            return {$urandom, $urandom};
        end else if (pick <= 8) begin
            return plane_of(sel == 0 ? mag : 0, sel == 1 ? mag : 0, sel == 2 ? mag : 0,
                            $urandom_range(0, 16383));
        end else begin
            return plane_of(ext[$urandom_range(0, 2)], ext[$urandom_range(0, 2)],
                            ext[$urandom_range(0, 2)], ext[$urandom_range(0, 2)]);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic want, input logic got);
        $display("mismatch at result %0d: %s, expected %b got %b",
                 results_seen, what, want, got);
        mismatches++;
    endtask

    // offer one item, optionally after a gap, and hold it until taken
    task automatic offer_query(input cull_query_t q);
        int gap;
        gap = (in_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= q.kind;
        i_center_x <= q.cx;
        i_center_y <= q.cy;
        i_center_z <= q.cz;
        i_extent_x <= q.ex;
        i_extent_y <= q.ey;
        i_extent_z <= q.ez;
        do @(posedge i_clk); while (o_in_stall);
        vis_expected.push_back(predict_visible(q));
    endtask

    // stop offering and wait for every outstanding result
    task automatic settle_pipeline();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (vis_expected.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PLANE_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx < REG_COUNT) begin
            plane_model[idx] = data;
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // write a full frustum once the block is idle
    task automatic load_planes(input logic [PLANE_W-1:0] near_p, input logic [PLANE_W-1:0] far_p,
                               input logic [PLANE_W-1:0] left_p, input logic [PLANE_W-1:0] right_p,
                               input logic [PLANE_W-1:0] top_p, input logic [PLANE_W-1:0] bot_p);
        settle_pipeline();
        write_reg(REG_PLANE_NEAR, near_p);
        write_reg(REG_PLANE_FAR, far_p);
        write_reg(REG_PLANE_LEFT, left_p);
        write_reg(REG_PLANE_RIGHT, right_p);
        write_reg(REG_PLANE_TOP, top_p);
        write_reg(REG_PLANE_BOTTOM, bot_p);
        if ($urandom_range(0, 2) == 0) begin
            write_reg($urandom_range(0, 1) ? IDX_SPARE_HI : IDX_SPARE_LO, {$urandom, $urandom});
        end
    endtask

    // reset planes are all zero, so everything is visible
    task automatic test_after_reset();
        offer_query(query_of(OP_POINT, -32768, -32768, -32768, 0, 0, 0));
        offer_query(query_of(OP_BOX, 32767, 32767, 32767, 32767, 32767, 32767));
        offer_query(query_of(OP_SPHERE, -32768, 32767, 0, 0, 32767, 32767));
    endtask

    // cube of half side 1600: exact boundaries for every query kind
    task automatic test_cube_edges();
        load_planes(plane_of(0, 0, ONE_Q13, HALF_SIDE), plane_of(0, 0, -ONE_Q13, HALF_SIDE),
                    plane_of(ONE_Q13, 0, 0, HALF_SIDE), plane_of(-ONE_Q13, 0, 0, HALF_SIDE),
                    plane_of(0, -ONE_Q13, 0, HALF_SIDE), plane_of(0, ONE_Q13, 0, HALF_SIDE));
        offer_query(query_of(OP_POINT, 0, 0, 0, 0, 0, 0));
        offer_query(query_of(OP_POINT, -HALF_SIDE, 0, 0, 0, 0, 0));
        offer_query(query_of(OP_POINT, -HALF_SIDE - 1, 0, 0, 0, 0, 0));
        // unused extents on a point
        offer_query(query_of(OP_POINT, 0, HALF_SIDE, 0, 32767, 32767, 32767));
        offer_query(query_of(OP_POINT, 0, 0, HALF_SIDE + 1, 32767, 32767, 32767));
        // sphere touching the plane, then just short of it
        offer_query(query_of(OP_SPHERE, -HALF_SIDE - 100, 0, 0, 100, 32767, 32767));
        offer_query(query_of(OP_SPHERE, -HALF_SIDE - 100, 0, 0, 99, 32767, 32767));
        offer_query(query_of(OP_SPHERE, 0, 0, 0, 0, 0, 0));
        offer_query(query_of(OP_BOX, -HALF_SIDE - 100, 0, 0, 100, 0, 0));
        offer_query(query_of(OP_BOX, -HALF_SIDE - 100, 0, 0, 99, 0, 0));
        // reserved kind behaves as a box
        offer_query(query_of(OP_RESERVED, -HALF_SIDE - 100, 0, 0, 100, 0, 0));
        offer_query(query_of(OP_RESERVED, 0, HALF_SIDE + 100, 0, 0, 99, 0));
        offer_query(query_of(OP_BOX, -32768, -32768, -32768, 32767, 32767, 32767));
        offer_query(query_of(OP_POINT, 32767, 32767, 32767, 0, 0, 0));
        // writes past the last plane leave the frustum alone
        settle_pipeline();
        write_reg(IDX_SPARE_LO, {PLANE_W{1'b1}});
        write_reg(IDX_SPARE_HI, plane_of(0, 0, 0, -32768));
        offer_query(query_of(OP_POINT, 0, 0, 0, 0, 0, 0));
        offer_query(query_of(OP_POINT, -HALF_SIDE - 1, 0, 0, 0, 0, 0));
    endtask

    // full-scale coefficients against full-scale queries
    task automatic test_extreme_planes();
        load_planes(plane_of(-32768, 32767, -32768, 32767), plane_of(32767, -32768, 32767, -32768),
                    plane_of(0, 0, 0, 0), plane_of(0, 0, 0, 0),
                    plane_of(0, 0, 0, 0), plane_of(0, 0, 0, 0));
        offer_query(query_of(OP_POINT, -32768, -32768, -32768, 0, 0, 0));
        offer_query(query_of(OP_POINT, 32767, 32767, 32767, 0, 0, 0));
        offer_query(query_of(OP_BOX, -32768, 32767, -32768, 32767, 32767, 32767));
        offer_query(query_of(OP_SPHERE, 32767, -32768, 32767, 32767, 0, 0));
        offer_query(query_of(OP_POINT, 0, 0, 0, 0, 0, 0));
        // a plane with no normal and negative offset rejects everything
        load_planes(plane_of(0, 0, 0, -32768), plane_of(0, 0, 0, 0), plane_of(0, 0, 0, 0),
                    plane_of(0, 0, 0, 0), plane_of(0, 0, 0, 0), plane_of(0, 0, 0, 32767));
        offer_query(query_of(OP_BOX, 0, 0, 0, 32767, 32767, 32767));
        offer_query(query_of(OP_SPHERE, 0, 0, 0, 32767, 0, 0));
    endtask

    // random frusta, each with a stream of random queries
    task automatic test_random_frusta();
        for (int phase = 0; phase < 8; phase++) begin
            load_planes(random_plane(), random_plane(), random_plane(),
                        random_plane(), random_plane(), random_plane());
            in_idle_on = ($urandom_range(0, 3) != 0);
            out_idle_on = ($urandom_range(0, 3) != 0);
            repeat (150) offer_query(random_query());
        end
    endtask

    // long receiver hold while items keep coming
    task automatic test_backpressure();
        in_idle_on = 1'b0;
        out_idle_on = 1'b1;
        holds_asked++;
        repeat (200) offer_query(random_query());
    endtask

    // last stretch at full rate, no idling anywhere
    task automatic test_full_rate();
        load_planes(random_plane(), random_plane(), random_plane(),
                    random_plane(), random_plane(), random_plane());
        in_idle_on = 1'b0;
        out_idle_on = 1'b0;
        repeat (200) offer_query(random_query());
    endtask

    // result stall: long holds on request, else random bursts
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (holds_served != holds_asked) begin
            i_out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            holds_served <= holds_served + 1;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (out_idle_on && $urandom_range(0, 7) == 0) begin
            i_out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 15);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // compare each result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && took_out) begin
            if (vis_expected.size() == 0) begin
                report_mismatch("result with nothing outstanding", 1'bx, o_visible);
            end else begin
                want_vis = vis_expected.pop_front();
                if (o_visible !== want_vis) begin
                    report_mismatch("visible", want_vis, o_visible);
                end
            end
            results_seen++;
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (!i_rst_n || took_in || took_out || took_cfg) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // reset, then the tests in turn
    initial begin
        foreach (plane_model[n]) begin
            plane_model[n] = '0;
        end
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        in_idle_on = 1'b1;
        out_idle_on = 1'b1;
        test_after_reset();
        test_cube_edges();
        test_extreme_planes();
        test_random_frusta();
        test_backpressure();
        test_full_rate();
        settle_pipeline();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- frustum_cull_test.f -----
hw/rtl/fcull_pkg.sv
hw/rtl/fcull_cell.sv
hw/rtl/frustum_cull_test.sv
sim/tb_top.sv
